// File: rtl/core/bbce_pkg.sv
package bbce_pkg;

  localparam int ID_W    = 32;
  localparam int SIZE_W  = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 48;
  localparam int NEED_W  = 40;
  localparam int TOTAL_W = 39;
  localparam int FREED_W = 41;
  localparam int ENTRY_W = ID_W + SIZE_W + CNT_W + STAMP_W;
  localparam int KEY_W   = CNT_W + STAMP_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EVICT  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_ABSENT = 3'd1,
    ST_FULL   = 3'd2,
    ST_VICTIM = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last;
  } sts_t;

endpackage

// File: rtl/core/bbce_ram.sv
module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bbce_ctrl.sv
module bbce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_stall,
  input  bbce_pkg::sts_t      sts,
  output bbce_pkg::cmd_t      cmd,
  output logic                in_stall,
  output logic                out_valid
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_HOLD);

endmodule

// File: rtl/core/bbce_dp.sv
module bbce_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bbce_pkg::cmd_t                  cmd,
  output bbce_pkg::sts_t                  sts,
  input  logic                            policy,
  input  logic [1:0]                      in_req_type,
  input  logic [bbce_pkg::ID_W-1:0]       in_block_id,
  input  logic [bbce_pkg::SIZE_W-1:0]     in_block_size,
  input  logic [bbce_pkg::NEED_W-1:0]     in_bytes_needed,
  output logic [2:0]                      out_status,
  output logic [31:0]                     out_victim_id,
  output logic [31:0]                     out_victim_size,
  output logic                            out_last_of_run,
  output logic [6:0]                      out_cached_count,
  output logic [37:0]                     out_cached_bytes
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int HELD_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // request
  bbce_pkg::req_t                  req_r;
  logic [bbce_pkg::ID_W-1:0]       key_id_r;
  logic [bbce_pkg::SIZE_W-1:0]     key_size_r;
  logic [bbce_pkg::NEED_W-1:0]     need_r;

  // global state
  logic [TABLE_ENTRIES-1:0]        valid_r, valid_nxt;
  logic [bbce_pkg::STAMP_W-1:0]    stamp_r, stamp_nxt;
  logic [bbce_pkg::TOTAL_W-1:0]    total_r, total_nxt;
  logic [HELD_W-1:0]               held_r, held_nxt;
  logic [bbce_pkg::FREED_W-1:0]    freed_r, freed_nxt;

  // scan pipeline
  logic                            scan_act_r;
  logic [IDX_W-1:0]                idx_r;
  logic                            pend_r;
  logic [IDX_W-1:0]                pidx_r;
  logic                            plast_r;

  // trackers
  logic                            hit_r, free_r, best_r;
  logic [IDX_W-1:0]                hit_idx_r, free_idx_r, best_idx_r;
  logic [bbce_pkg::SIZE_W-1:0]     hit_bytes_r, best_bytes_r;
  logic [bbce_pkg::CNT_W-1:0]      hit_cnt_r;
  logic [bbce_pkg::ID_W-1:0]       best_id_r;
  logic [bbce_pkg::KEY_W-1:0]      best_key_r;

  // memory
  logic                            we;
  logic [IDX_W-1:0]                waddr;
  logic [bbce_pkg::ENTRY_W-1:0]    wdata, rdata;

  logic [bbce_pkg::ID_W-1:0]       rd_id;
  logic [bbce_pkg::SIZE_W-1:0]     rd_bytes;
  logic [bbce_pkg::CNT_W-1:0]      rd_cnt;
  logic [bbce_pkg::STAMP_W-1:0]    rd_stamp;
  logic [bbce_pkg::KEY_W-1:0]      rd_key;
  logic                            rd_valid;

  // result
  logic [2:0]                      st_nxt;
  logic [31:0]                     vid_nxt, vsize_nxt;
  logic                            last_nxt, last_r;
  logic [bbce_pkg::CNT_W-1:0]      cnt_ref;
  logic [31:0]                     held_ext;

  logic [2:0]                      st_r;
  logic [31:0]                     vid_r, vsize_r;
  logic [6:0]                      ccount_r;
  logic [37:0]                     cbytes_r;

  bbce_ram #(
    .WIDTH (bbce_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign rd_id    = rdata[bbce_pkg::ENTRY_W-1 -: bbce_pkg::ID_W];
  assign rd_bytes = rdata[bbce_pkg::KEY_W+bbce_pkg::SIZE_W-1 -: bbce_pkg::SIZE_W];
  assign rd_cnt   = rdata[bbce_pkg::KEY_W-1 -: bbce_pkg::CNT_W];
  assign rd_stamp = rdata[bbce_pkg::STAMP_W-1:0];
  assign rd_key   = policy ? {rd_cnt, rd_stamp} : {{bbce_pkg::CNT_W{1'b0}}, rd_stamp};
  assign rd_valid = valid_r[pidx_r];

  assign sts.scan_done = pend_r && plast_r;
  assign sts.last      = last_r;

  // scan: walk every slot once, one read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      pend_r     <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_act_r <= 1'b1;
      pend_r     <= 1'b0;
    end else begin
      if (scan_act_r && idx_r == LAST_IDX) begin
        scan_act_r <= 1'b0;
      end
      pend_r <= scan_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (scan_act_r) begin
      idx_r <= idx_r + 1'b1;
    end
    pidx_r  <= idx_r;
    plast_r <= (idx_r == LAST_IDX);
  end

  // trackers: first hit, lowest free slot, best victim (ties keep lower slot)
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      best_r <= 1'b0;
    end else if (pend_r) begin
      if (rd_valid && !hit_r && rd_id == key_id_r) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= pidx_r;
        hit_bytes_r <= rd_bytes;
        hit_cnt_r   <= rd_cnt;
      end
      if (!rd_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= pidx_r;
      end
      if (rd_valid && (!best_r || rd_key < best_key_r)) begin
        best_r       <= 1'b1;
        best_idx_r   <= pidx_r;
        best_id_r    <= rd_id;
        best_bytes_r <= rd_bytes;
        best_key_r   <= rd_key;
      end
    end
  end

  // apply the request
  always_comb begin
    valid_nxt = valid_r;
    stamp_nxt = stamp_r;
    total_nxt = total_r;
    held_nxt  = held_r;
    freed_nxt = freed_r;
    we        = 1'b0;
    waddr     = hit_idx_r;
    wdata     = '0;
    st_nxt    = bbce_pkg::ST_DONE;
    vid_nxt   = '0;
    vsize_nxt = '0;
    last_nxt  = 1'b1;
    cnt_ref   = (policy && hit_cnt_r != bbce_pkg::CNT_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;
    unique case (req_r)
      bbce_pkg::REQ_ACCESS: begin
        if (hit_r) begin
          we        = 1'b1;
          wdata     = {key_id_r, hit_bytes_r, cnt_ref, stamp_r};
          stamp_nxt = stamp_r + 1'b1;
        end else begin
          st_nxt = bbce_pkg::ST_ABSENT;
        end
      end
      bbce_pkg::REQ_INSERT: begin
        if (hit_r) begin
          we        = 1'b1;
          wdata     = {key_id_r, key_size_r, cnt_ref, stamp_r};
          stamp_nxt = stamp_r + 1'b1;
          total_nxt = total_r - bbce_pkg::TOTAL_W'(hit_bytes_r)
                      + bbce_pkg::TOTAL_W'(key_size_r);
        end else if (free_r) begin
          we                    = 1'b1;
          waddr                 = free_idx_r;
          wdata                 = {key_id_r, key_size_r, bbce_pkg::CNT_W'(1), stamp_r};
          stamp_nxt             = stamp_r + 1'b1;
          total_nxt             = total_r + bbce_pkg::TOTAL_W'(key_size_r);
          held_nxt              = held_r + 1'b1;
          valid_nxt[free_idx_r] = 1'b1;
        end else begin
          st_nxt = bbce_pkg::ST_FULL;
        end
      end
      bbce_pkg::REQ_REMOVE: begin
        if (hit_r) begin
          valid_nxt[hit_idx_r] = 1'b0;
          total_nxt            = total_r - bbce_pkg::TOTAL_W'(hit_bytes_r);
          held_nxt             = held_r - 1'b1;
        end else begin
          st_nxt = bbce_pkg::ST_ABSENT;
        end
      end
      bbce_pkg::REQ_EVICT: begin
        if (need_r == '0 || !best_r) begin
          st_nxt = bbce_pkg::ST_NONE;
        end else begin
          valid_nxt[best_idx_r] = 1'b0;
          total_nxt = total_r - bbce_pkg::TOTAL_W'(best_bytes_r);
          held_nxt  = held_r - 1'b1;
          freed_nxt = freed_r + bbce_pkg::FREED_W'(best_bytes_r);
          st_nxt    = bbce_pkg::ST_VICTIM;
          vid_nxt   = best_id_r;
          vsize_nxt = best_bytes_r;
          last_nxt  = (freed_nxt >= bbce_pkg::FREED_W'(need_r)) || (held_nxt == '0);
        end
      end
      default: st_nxt = bbce_pkg::ST_NONE;
    endcase
    held_ext = 32'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      stamp_r <= '0;
      total_r <= '0;
      held_r  <= '0;
      last_r  <= 1'b1;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
      stamp_r <= stamp_nxt;
      total_r <= total_nxt;
      held_r  <= held_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= bbce_pkg::req_t'(in_req_type);
      key_id_r   <= in_block_id;
      key_size_r <= in_block_size;
      need_r     <= in_bytes_needed;
      freed_r    <= '0;
    end else if (cmd.exec) begin
      freed_r <= freed_nxt;
    end
    if (cmd.exec) begin
      st_r     <= st_nxt;
      vid_r    <= vid_nxt;
      vsize_r  <= vsize_nxt;
      ccount_r <= held_ext[6:0];
      cbytes_r <= total_nxt[37:0];
    end
  end

  assign out_status       = st_r;
  assign out_victim_id    = vid_r;
  assign out_victim_size  = vsize_r;
  assign out_last_of_run  = last_r;
  assign out_cached_count = ccount_r;
  assign out_cached_bytes = cbytes_r;

endmodule

// File: rtl/core/byte_budget_cache_evictor_unit.sv
// Cache replacement table with a byte budget (LRU or LFU).
// Input channel (in_*): one request per transfer: access, insert, remove or
//   evict. A transfer happens when in_valid is high and in_stall is low.
// Result channel (out_*): access, insert and remove give one result each;
//   evict gives one result per victim, the final one with out_last_of_run.
// Config port (cfg_*): APB-style; policy_mode at byte address 0
//   (0 least recently used, 1 least frequently used). Write only while idle.
// Scan: each request scans the whole table through the entry RAM, one
//   slot per cycle, before its result is applied and registered. Every
//   further victim of an evict costs another scan of the whole table after
//   the previous result is taken. One request at a time: a new request
//   waits until the final result of the last one is taken, and the single
//   read port of the entry RAM makes each scan walk the table slot by slot.
// Reset: all slots empty, stamp, byte total and block count zero, LRU mode.
// Stall: a result waits in the output register while out_stall is high,
//   and the block takes no new request until the run is done.
module byte_budget_cache_evictor_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_block_id,
  input  logic [31:0] in_block_size,
  input  logic [39:0] in_bytes_needed,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_victim_id,
  output logic [31:0] out_victim_size,
  output logic        out_last_of_run,
  output logic [6:0]  out_cached_count,
  output logic [37:0] out_cached_bytes,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bbce_pkg::cmd_t cmd;
  bbce_pkg::sts_t sts;
  logic           policy_r;
  logic           cfg_wr;

  // Register write on the access phase; word 0 holds the policy bit.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      policy_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {31'd0, policy_r};

  // Sequencer: accept, scan, apply, hold the result until transferred.
  bbce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Table, scan trackers, totals and the output register.
  bbce_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .policy           (policy_r),
    .in_req_type      (in_req_type),
    .in_block_id      (in_block_id),
    .in_block_size    (in_block_size),
    .in_bytes_needed  (in_bytes_needed),
    .out_status       (out_status),
    .out_victim_id    (out_victim_id),
    .out_victim_size  (out_victim_size),
    .out_last_of_run  (out_last_of_run),
    .out_cached_count (out_cached_count),
    .out_cached_bytes (out_cached_bytes)
  );

endmodule

// File: verif/tb_byte_budget_cache_evictor_unit.sv
module tb_byte_budget_cache_evictor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int REQ_CAP = 512;
  localparam int EXP_CAP = 2048;
  localparam int POOL_CAP = 24;

  typedef struct {
    bbce_pkg::req_t kind;
    logic [31:0]    id;
    logic [31:0]    size;
    logic [39:0]    need;
  } request_t;

  typedef struct {
    bbce_pkg::status_t status;
    logic [31:0]       vid;
    logic [31:0]       vsize;
    logic              last;
    logic [6:0]        count;
    logic [37:0]       bytes;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [31:0] in_block_id;
  logic [31:0] in_block_size;
  logic [39:0] in_bytes_needed;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_victim_id;
  logic [31:0] out_victim_size;
  logic        out_last_of_run;
  logic [6:0]  out_cached_count;
  logic [37:0] out_cached_bytes;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  byte_budget_cache_evictor_unit u_top (.*);

  // Shadow of the replacement table
  logic        sh_valid [SLOTS];
  logic [31:0] sh_id    [SLOTS];
  logic [31:0] sh_bytes [SLOTS];
  logic [31:0] sh_count [SLOTS];
  logic [47:0] sh_stamp [SLOTS];
  logic [47:0] sh_clock;
  logic [38:0] sh_total;
  logic [6:0]  sh_held;
  logic        sh_lfu;

  request_t    req_q [REQ_CAP];
  int          req_head, req_tail;
  outcome_t    exp_q [EXP_CAP];
  int          exp_head, exp_tail;
  int          errors;
  int          idle_cycles;
  bit          sending_on;
  int          burst_left, gap_left;
  int          hold_off;
  logic        in_fire;
  logic [31:0] id_pool [POOL_CAP];
  int          pool_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void touch(int s);
    if (sh_lfu && sh_count[s] != bbce_pkg::CNT_MAX) sh_count[s]++;
    sh_stamp[s] = sh_clock;
    sh_clock++;
  endfunction

  function automatic int choose_victim();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!sh_valid[i]) continue;
      if (best < 0) best = i;
      else if (sh_lfu) begin
        if (sh_count[i] < sh_count[best] ||
            (sh_count[i] == sh_count[best] && sh_stamp[i] < sh_stamp[best]))
          best = i;
      end else if (sh_stamp[i] < sh_stamp[best]) best = i;
    end
    return best;
  endfunction

  function automatic void push_outcome(bbce_pkg::status_t st, logic [31:0] vid,
                                       logic [31:0] vsz, logic last);
    outcome_t o;
    o.status = st; o.vid = vid; o.vsize = vsz; o.last = last;
    o.count = sh_held; o.bytes = sh_total[37:0];
    exp_q[exp_tail] = o;
    exp_tail++;
  endfunction

  // Advance the shadow table by one request and queue its results
  function automatic void predict_evictions(request_t r);
    int s, n;
    logic [40:0] freed;
    case (r.kind)
      bbce_pkg::REQ_ACCESS: begin
        s = find_id(r.id);
        if (s < 0) push_outcome(bbce_pkg::ST_ABSENT, '0, '0, 1'b1);
        else begin
          touch(s);
          push_outcome(bbce_pkg::ST_DONE, '0, '0, 1'b1);
        end
      end
      bbce_pkg::REQ_INSERT: begin
        s = find_id(r.id);
        if (s >= 0) begin
          sh_total = sh_total - sh_bytes[s] + r.size;
          sh_bytes[s] = r.size;
          touch(s);
          push_outcome(bbce_pkg::ST_DONE, '0, '0, 1'b1);
        end else begin
          s = -1;
          for (int i = SLOTS - 1; i >= 0; i--) if (!sh_valid[i]) s = i;
          if (s < 0) push_outcome(bbce_pkg::ST_FULL, '0, '0, 1'b1);
          else begin
            sh_valid[s] = 1'b1; sh_id[s] = r.id; sh_bytes[s] = r.size;
            sh_count[s] = 32'd1; sh_stamp[s] = sh_clock; sh_clock++;
            sh_total = sh_total + r.size;
            sh_held++;
            push_outcome(bbce_pkg::ST_DONE, '0, '0, 1'b1);
          end
        end
      end
      bbce_pkg::REQ_REMOVE: begin
        s = find_id(r.id);
        if (s < 0) push_outcome(bbce_pkg::ST_ABSENT, '0, '0, 1'b1);
        else begin
          sh_valid[s] = 1'b0;
          sh_total = sh_total - sh_bytes[s];
          sh_held--;
          push_outcome(bbce_pkg::ST_DONE, '0, '0, 1'b1);
        end
      end
      default: begin
        n = 0; freed = '0;
        while (freed < r.need && n < SLOTS) begin
          s = choose_victim();
          if (s < 0) break;
          sh_valid[s] = 1'b0;
          freed += sh_bytes[s];
          sh_total = sh_total - sh_bytes[s];
          sh_held--;
          push_outcome(bbce_pkg::ST_VICTIM, sh_id[s], sh_bytes[s], 1'b0);
          n++;
        end
        if (n == 0) push_outcome(bbce_pkg::ST_NONE, '0, '0, 1'b1);
        else exp_q[exp_tail - 1].last = 1'b1;
      end
    endcase
  endfunction

  // Driver: bursts and gaps; payload holds until transferred
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (sending_on) begin
          if (burst_left == 0) begin
            sending_on <= 1'b0;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else burst_left <= burst_left - 1;
        end else if (gap_left == 0) begin
          sending_on <= 1'b1;
          burst_left <= $urandom_range(1, 8);
        end else gap_left <= gap_left - 1;
        if (sending_on && req_head < req_tail) begin
          in_valid        <= 1'b1;
          in_req_type     <= req_q[req_head].kind;
          in_block_id     <= req_q[req_head].id;
          in_block_size   <= req_q[req_head].size;
          in_bytes_needed <= req_q[req_head].need;
          req_head        <= req_head + 1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall pattern, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 299) == 0) begin
        hold_off <= $urandom_range(300, 600);
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin
    request_t r;
    outcome_t e;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        r.kind = bbce_pkg::req_t'(in_req_type); r.id = in_block_id;
        r.size = in_block_size; r.need = in_bytes_needed;
        predict_evictions(r);
      end
      if (out_valid && !out_stall) begin
        if (exp_head >= exp_tail) begin
          $error("unexpected result transfer, status %0d", out_status);
          errors++;
        end else begin
          e = exp_q[exp_head];
          exp_head++;
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
          if (out_victim_id !== e.vid) begin
            $error("victim_id exp %h got %h", e.vid, out_victim_id); errors++;
          end
          if (out_victim_size !== e.vsize) begin
            $error("victim_size exp %h got %h", e.vsize, out_victim_size); errors++;
          end
          if (out_last_of_run !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, out_last_of_run); errors++;
          end
          if (out_cached_count !== e.count) begin
            $error("cached_count exp %0d got %0d", e.count, out_cached_count);
            errors++;
          end
          if (out_cached_bytes !== e.bytes) begin
            $error("cached_bytes exp %h got %h", e.bytes, out_cached_bytes);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL byte_budget_cache_evictor_unit");
      $finish;
    end
  end

  function automatic void add_req(bbce_pkg::req_t k, logic [31:0] id, logic [31:0] sz,
                                  logic [39:0] nd);
    request_t r;
    r.kind = k; r.id = id; r.size = sz; r.need = nd;
    req_q[req_tail] = r;
    req_tail++;
  endfunction

  function automatic logic [31:0] pick_id();
    if (pool_cnt > 0 && $urandom_range(0, 4) != 0)
      return id_pool[$urandom_range(0, pool_cnt - 1)];
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return 32'($urandom_range(1, 4096));
    endcase
  endfunction

  // Random well-formed traffic: mostly inserts and refreshes on a known pool
  function automatic void add_random(int n);
    int k;
    logic [39:0] nd;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        if (pool_cnt < POOL_CAP) begin
          id_pool[pool_cnt] = $urandom();
          pool_cnt++;
        end
        add_req(bbce_pkg::REQ_INSERT, pick_id(), rand_size(),
                {$urandom(), 8'($urandom())});
      end else if (k < 7)
        add_req(bbce_pkg::REQ_ACCESS, pick_id(), $urandom(),
                {$urandom(), 8'($urandom())});
      else if (k < 8)
        add_req(bbce_pkg::REQ_REMOVE, pick_id(), $urandom(),
                {$urandom(), 8'($urandom())});
      else begin
        case ($urandom_range(0, 3))
          0: nd = {$urandom(), 8'($urandom())};
          1: nd = 40'hFF_FFFF_FFFF;
          default: nd = 40'($urandom_range(0, 8000));
        endcase
        add_req(bbce_pkg::REQ_EVICT, $urandom(), $urandom(), nd);
      end
    end
  endfunction

  task automatic cfg_write(logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= 3'd0; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sh_lfu = val[0];
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Let the queued requests drain, then allow the block to go quiet
  task automatic drain();
    while (req_head < req_tail || in_valid || exp_head < exp_tail)
      @(posedge clk);
    repeat (SLOTS + 10) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_req_type = '0; in_block_id = '0;
    in_block_size = '0; in_bytes_needed = '0; out_stall = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; idle_cycles = 0; sending_on = 1'b1; burst_left = 4;
    gap_left = 0; in_fire = 1'b0;
    // start with a long hold-off so the first result waits and the block stalls its input
    hold_off = 400;
    req_head = 0; req_tail = 0; exp_head = 0; exp_tail = 0; pool_cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0; sh_id[i] = '0; sh_bytes[i] = '0;
      sh_count[i] = '0; sh_stamp[i] = '0;
    end
    sh_clock = '0; sh_total = '0; sh_held = '0; sh_lfu = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty-table cases, extremes, replace, then a full table
    add_req(bbce_pkg::REQ_EVICT, '0, '0, 40'd100);
    add_req(bbce_pkg::REQ_ACCESS, 32'hFFFF_FFFF, '0, '0);
    add_req(bbce_pkg::REQ_REMOVE, '0, '0, '0);
    add_req(bbce_pkg::REQ_INSERT, 32'h0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    add_req(bbce_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0, '0);
    add_req(bbce_pkg::REQ_INSERT, 32'h0, 32'h10, '0);
    add_req(bbce_pkg::REQ_EVICT, '0, '0, 40'd0);
    add_req(bbce_pkg::REQ_ACCESS, 32'h0, '0, '0);
    add_req(bbce_pkg::REQ_REMOVE, 32'hFFFF_FFFF, '0, '0);
    add_req(bbce_pkg::REQ_EVICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    for (int i = 0; i < SLOTS + 1; i++)
      add_req(bbce_pkg::REQ_INSERT, 32'(i + 100), 32'hFFFF_FFFF, '0);
    add_req(bbce_pkg::REQ_EVICT, '0, '0, 40'hFF_FFFF_FFFF);
    drain();

    // LFU: unequal counts, then random traffic in both modes
    cfg_write(32'd1);
    add_req(bbce_pkg::REQ_INSERT, 32'd1, 32'd5, '0);
    add_req(bbce_pkg::REQ_INSERT, 32'd2, 32'd6, '0);
    add_req(bbce_pkg::REQ_ACCESS, 32'd1, '0, '0);
    add_req(bbce_pkg::REQ_EVICT, '0, '0, 40'd1);
    add_random(55);
    drain();
    cfg_write(32'd0);
    add_random(45);
    drain();
    cfg_write(32'hFFFF_FFFF);
    add_random(45);
    add_req(bbce_pkg::REQ_EVICT, '0, '0, 40'hFF_FFFF_FFFF);
    drain();

    if (errors == 0) $display("PASS byte_budget_cache_evictor_unit");
    else $display("FAIL byte_budget_cache_evictor_unit");
    $finish;
  end
endmodule

// File: sim.f
rtl/core/bbce_pkg.sv
rtl/core/bbce_ram.sv
rtl/core/bbce_ctrl.sv
rtl/core/bbce_dp.sv
rtl/core/byte_budget_cache_evictor_unit.sv
verif/tb_byte_budget_cache_evictor_unit.sv
